/* design/ptc_pkg.sv */
package ptc_pkg;

  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [15:0] EtherArp  = 16'h0806;
  localparam logic [31:0] Loopback  = 32'h7F00_0001;
  localparam logic [31:0] HashMult  = 32'd2654435761;
  localparam int unsigned LoginPorts = 7;

  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] ProtoIcmp = 8'd1;

  localparam logic [2:0] CfgLocal0     = 3'd0;
  localparam logic [2:0] CfgLocal1     = 3'd1;
  localparam logic [2:0] CfgSynLimit   = 3'd2;
  localparam logic [2:0] CfgUdpLimit   = 3'd3;
  localparam logic [2:0] CfgIcmpLimit  = 3'd4;
  localparam logic [2:0] CfgBruteLimit = 3'd5;
  localparam logic [2:0] CfgWindow     = 3'd6;

  typedef enum logic [3:0] {
    ClsArp = 4'd0, ClsSyn = 4'd1, ClsSynAck = 4'd2, ClsFin = 4'd3, ClsRst = 4'd4,
    ClsAck = 4'd5, ClsTcpOther = 4'd6, ClsUdp = 4'd7, ClsIcmp = 4'd8, ClsOther = 4'd9
  } pkt_class_t;

  typedef enum logic [1:0] {
    FloodNone = 2'd0, FloodSyn = 2'd1, FloodUdp = 2'd2, FloodIcmp = 2'd3
  } flood_kind_t;

  // One classified item, passed from the front part to the table part.
  typedef struct packed {
    pkt_class_t  cls;
    logic        scan;
    logic        probe;
    logic        src_local;
    logic        dst_local;
    flood_kind_t flood_kind;
    logic        brute_use;
    logic [2:0]  port_slot;
    logic [31:0] src;
    logic [31:0] now;
  } job_t;

  typedef enum logic [1:0] {
    StIdle = 2'd0, StRead = 2'd1, StUpdate = 2'd2
  } back_state_t;

  function automatic logic [2:0] login_slot(input logic [15:0] port, output logic hit);
    hit = 1'b1;
    case (port)
      16'd22:   login_slot = 3'd0;
      16'd23:   login_slot = 3'd1;
      16'd3389: login_slot = 3'd2;
      16'd5900: login_slot = 3'd3;
      16'd21:   login_slot = 3'd4;
      16'd3306: login_slot = 3'd5;
      16'd1433: login_slot = 3'd6;
      default: begin
        login_slot = 3'd0;
        hit = 1'b0;
      end
    endcase
  endfunction

endpackage

/* design/ptc_ram.sv */
module ptc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/ptc_front.sv */
module ptc_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] frame_length,
  input  logic [15:0] ether_type,
  input  logic [3:0]  header_words,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] dst_port,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [31:0] now_seconds,
  input  logic [31:0] local_addr_0,
  input  logic [31:0] local_addr_1,
  output logic        job_valid,
  input  logic        job_ready,
  output ptc_pkg::job_t job
);

  // Two-entry queue towards the table part.
  ptc_pkg::job_t q [2];
  logic          rd_ptr, wr_ptr;
  logic [1:0]    fill;
  ptc_pkg::job_t cj;
  logic          keep;
  logic          sl, dl, syn, ack, out_in, lhit, udp_short;
  logic [2:0]    lslot;
  logic [16:0]   udp_min;

  function automatic logic local_match(input logic [31:0] a, input logic [31:0] l0,
                                       input logic [31:0] l1);
    local_match = (a == ptc_pkg::Loopback) || (l0 != 32'd0 && a == l0) ||
                  (l1 != 32'd0 && a == l1);
  endfunction

  assign in_ready  = (fill != 2'd2);
  assign job_valid = (fill != 2'd0);
  assign job       = q[rd_ptr];

  always_comb begin
    sl      = local_match(src_addr, local_addr_0, local_addr_1);
    dl      = local_match(dst_addr, local_addr_0, local_addr_1);
    syn     = tcp_flag_bits[1];
    ack     = tcp_flag_bits[4];
    out_in  = !sl && dl;
    lslot   = ptc_pkg::login_slot(dst_port, lhit);
    udp_min = 17'd22 + {11'd0, header_words, 2'b00};
    udp_short = {1'b0, frame_length} < udp_min;
    keep    = 1'b0;
    cj      = '0;
    cj.cls  = ptc_pkg::ClsOther;
    cj.src  = src_addr;
    cj.now  = now_seconds;
    cj.port_slot = lslot;
    cj.flood_kind = ptc_pkg::FloodNone;
    if (frame_length >= 16'd14) begin
      if (ether_type == ptc_pkg::EtherArp) begin
        keep   = 1'b1;
        cj.cls = ptc_pkg::ClsArp;
      end else if (ether_type == ptc_pkg::EtherIpv4 && frame_length >= 16'd34) begin
        keep = 1'b1;
        cj.src_local = sl;
        cj.dst_local = dl;
        case (ip_protocol)
          ptc_pkg::ProtoTcp: begin
            cj.brute_use = syn && out_in && lhit;
            if (syn && !ack && dl) cj.flood_kind = ptc_pkg::FloodSyn;
            if (syn && !ack && out_in) begin
              cj.cls  = ptc_pkg::ClsSyn;
              cj.scan = 1'b1;
            end else begin
              if (syn) begin
                cj.cls  = ack ? ptc_pkg::ClsSynAck : ptc_pkg::ClsSyn;
                cj.scan = !ack && dst_port < 16'd1024;
                case (dst_port)
                  16'd445, 16'd135, 16'd139, 16'd3389, 16'd22, 16'd23, 16'd1433,
                  16'd1434, 16'd3306: cj.probe = !ack;
                  default: cj.probe = 1'b0;
                endcase
              end else if (tcp_flag_bits[0]) cj.cls = ptc_pkg::ClsFin;
              else if (tcp_flag_bits[2]) cj.cls = ptc_pkg::ClsRst;
              else if (ack) cj.cls = ptc_pkg::ClsAck;
              else cj.cls = ptc_pkg::ClsTcpOther;
            end
          end
          ptc_pkg::ProtoUdp: begin
            keep   = !udp_short;
            cj.cls = ptc_pkg::ClsUdp;
            if (dl) cj.flood_kind = ptc_pkg::FloodUdp;
            case (dst_port)
              16'd53, 16'd161, 16'd162, 16'd1900, 16'd5353: cj.probe = out_in;
              default: cj.probe = 1'b0;
            endcase
          end
          ptc_pkg::ProtoIcmp: begin
            cj.cls = ptc_pkg::ClsIcmp;
            if (dl) cj.flood_kind = ptc_pkg::FloodIcmp;
          end
          default: cj.cls = ptc_pkg::ClsOther;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (in_valid && in_ready && keep) begin
        q[wr_ptr] <= cj;
        wr_ptr    <= !wr_ptr;
      end
      if (job_valid && job_ready) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, in_valid && in_ready && keep} - {1'b0, job_valid && job_ready};
    end
  end

endmodule

/* design/ptc_back.sv */
module ptc_back #(
  parameter int Sources = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  ptc_pkg::job_t job,
  input  logic [15:0]   syn_flood_limit,
  input  logic [15:0]   udp_flood_limit,
  input  logic [15:0]   icmp_flood_limit,
  input  logic [7:0]    brute_force_limit,
  input  logic [15:0]   window_seconds,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    packet_class,
  output logic          threat,
  output logic          flood_alert,
  output logic          brute_force_alert,
  output logic          scan_suspect,
  output logic          service_probe,
  output logic          src_is_local,
  output logic          dst_is_local
);

  localparam int Aw = (Sources > 1) ? $clog2(Sources) : 1;
  localparam int Fw = 32 + 16 + 32;
  localparam int Cw = 8 * ptc_pkg::LoginPorts;
  localparam int Bw = 32 + 32 + Cw;

  ptc_pkg::back_state_t state, state_next;
  ptc_pkg::job_t        cur;
  logic [31:0]          hash_prod;
  logic [Aw-1:0]        slot;
  logic [Sources-1:0]   fvalid, bvalid;

  logic          f_we, b_we;
  logic [Fw-1:0] f_wd, f_rd;
  logic [Bw-1:0] b_wd, b_rd;
  logic [5:0]    c_sel;
  logic [7:0]    c_rd, c_inc;
  logic [Cw-1:0] c_new;

  logic          take;
  logic          f_hit, b_hit;
  logic [15:0]   f_cnt_inc, f_lim;
  logic          flood_r, brute_r;

  assign job_ready = (state == ptc_pkg::StIdle) && !out_valid;
  assign take      = job_valid && job_ready;

  always_comb begin
    hash_prod = cur.src * ptc_pkg::HashMult;
    if (Sources > 1) slot = Aw'(hash_prod[31:16] % 16'(Sources));
    else slot = '0;
  end

  ptc_ram #(.Width(Fw), .Depth(Sources)) u_flood (
    .clk, .wr_en(f_we), .wr_addr(slot), .wr_data(f_wd), .rd_addr(slot), .rd_data(f_rd)
  );
  // A brute force row holds the tag, the window stamp and all login counters,
  // so a first sighting clears the other counters and starts its own in the same write.
  ptc_ram #(.Width(Bw), .Depth(Sources)) u_brute (
    .clk, .wr_en(b_we), .wr_addr(slot), .wr_data(b_wd), .rd_addr(slot), .rd_data(b_rd)
  );

  always_comb begin
    f_hit = fvalid[slot] && f_rd[79:48] == cur.src &&
            !((cur.now - f_rd[31:0]) > {16'd0, window_seconds});
    b_hit = bvalid[slot] && b_rd[Bw-1 -: 32] == cur.src &&
            !((cur.now - b_rd[Cw +: 32]) > {16'd0, window_seconds});
    f_cnt_inc = (f_rd[47:32] == 16'hFFFF) ? f_rd[47:32] : f_rd[47:32] + 16'd1;
    c_sel     = {cur.port_slot, 3'b000};
    c_rd      = b_rd[c_sel +: 8];
    c_inc     = (c_rd == 8'hFF) ? c_rd : c_rd + 8'd1;
    c_new     = b_hit ? b_rd[Cw-1:0] : '0;
    c_new[c_sel +: 8] = b_hit ? c_inc : 8'd1;
    case (cur.flood_kind)
      ptc_pkg::FloodSyn:  f_lim = syn_flood_limit;
      ptc_pkg::FloodUdp:  f_lim = udp_flood_limit;
      default:            f_lim = icmp_flood_limit;
    endcase
    f_we = (state == ptc_pkg::StUpdate) && cur.flood_kind != ptc_pkg::FloodNone;
    f_wd = f_hit ? {cur.src, f_cnt_inc, f_rd[31:0]} : {cur.src, 16'd1, cur.now};
    b_we = (state == ptc_pkg::StUpdate) && cur.brute_use;
    b_wd = {cur.src, (b_hit ? b_rd[Cw +: 32] : cur.now), c_new};
  end

  always_comb begin
    state_next = state;
    case (state)
      ptc_pkg::StIdle:   if (take) state_next = ptc_pkg::StRead;
      ptc_pkg::StRead:   state_next = ptc_pkg::StUpdate;
      ptc_pkg::StUpdate: state_next = ptc_pkg::StIdle;
      default:           state_next = ptc_pkg::StIdle;
    endcase
  end

  always_comb begin
    flood_r = f_we && f_hit && f_cnt_inc > f_lim;
    brute_r = b_we && b_hit && c_inc > brute_force_limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptc_pkg::StIdle;
      out_valid <= 1'b0;
      fvalid    <= '0;
      bvalid    <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ptc_pkg::StUpdate) begin
        out_valid <= 1'b1;
        if (f_we) fvalid[slot] <= 1'b1;
        if (b_we) bvalid[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= job;
    if (state == ptc_pkg::StUpdate) begin
      packet_class      <= cur.cls;
      flood_alert       <= flood_r;
      brute_force_alert <= brute_r;
      scan_suspect      <= cur.scan;
      service_probe     <= cur.probe;
      src_is_local      <= cur.src_local;
      dst_is_local      <= cur.dst_local;
      threat            <= flood_r || brute_r || cur.scan || cur.probe;
    end
  end

endmodule

/* design/packet_threat_classifier_top.sv */
// Channel  | Signals                                   | Transfer when
// in       | in_valid/in_ready, header fields          | in_valid && in_ready
// out      | out_valid/out_ready, class and flags      | out_valid && out_ready
// cfg      | cfg_we, cfg_index, cfg_data               | cfg_we
// The front part classifies an item in its accept cycle and queues it (two deep).
// The back part handles one item at a time in three steps (capture, table read,
// update) for the read-modify-write of the counter tables, and takes no new item
// until its result is taken. Frames that give no result never reach the queue.
// Synchronous reset clears the control state and the table valid bits at once.
// Either side may stall; the queue and the output register decouple them.
module packet_threat_classifier_top #(
  parameter int Sources = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] frame_length,
  input  logic [15:0] ether_type,
  input  logic [3:0]  header_words,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [31:0] now_seconds,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  packet_class,
  output logic        threat,
  output logic        flood_alert,
  output logic        brute_force_alert,
  output logic        scan_suspect,
  output logic        service_probe,
  output logic        src_is_local,
  output logic        dst_is_local
);

  logic [31:0] local_addr_0, local_addr_1;
  logic [15:0] syn_flood_limit, udp_flood_limit, icmp_flood_limit, window_seconds;
  logic [7:0]  brute_force_limit;
  logic          job_valid, job_ready;
  ptc_pkg::job_t job;
  logic [15:0]   unused_port;

  assign unused_port = src_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr_0      <= 32'd0;
      local_addr_1      <= 32'd0;
      syn_flood_limit   <= 16'd100;
      udp_flood_limit   <= 16'd150;
      icmp_flood_limit  <= 16'd50;
      brute_force_limit <= 8'd10;
      window_seconds    <= 16'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        ptc_pkg::CfgLocal0:     local_addr_0      <= cfg_data;
        ptc_pkg::CfgLocal1:     local_addr_1      <= cfg_data;
        ptc_pkg::CfgSynLimit:   syn_flood_limit   <= cfg_data[15:0];
        ptc_pkg::CfgUdpLimit:   udp_flood_limit   <= cfg_data[15:0];
        ptc_pkg::CfgIcmpLimit:  icmp_flood_limit  <= cfg_data[15:0];
        ptc_pkg::CfgBruteLimit: brute_force_limit <= cfg_data[7:0];
        ptc_pkg::CfgWindow:     window_seconds    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .frame_length, .ether_type, .header_words,
    .ip_protocol, .src_addr, .dst_addr, .dst_port, .tcp_flag_bits, .now_seconds,
    .local_addr_0, .local_addr_1, .job_valid, .job_ready, .job
  );

  ptc_back #(.Sources(Sources)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .syn_flood_limit, .udp_flood_limit,
    .icmp_flood_limit, .brute_force_limit, .window_seconds, .out_valid, .out_ready,
    .packet_class, .threat, .flood_alert, .brute_force_alert, .scan_suspect,
    .service_probe, .src_is_local, .dst_is_local
  );

endmodule
